// File: hdl/ppqb_pkg.sv
// Shared constants, codes and types for the plotter point queue with backlash correction.
package ppqb_pkg;

  // Default queue depth in points.
  localparam int PPQB_QUEUE_DEPTH = 64;

  // Field widths. The running correction is as wide as a target, so that it
  // wraps exactly as the issued target does when backlash settings change
  // between reversals.
  localparam int OP_W       = 2;
  localparam int COORD_W    = 24;
  localparam int POINT_W    = 24;
  localparam int TARGET_W   = 25;
  localparam int GAIN_W     = 24;
  localparam int OFFSET_W   = 32;
  localparam int BACKLASH_W = 16;
  localparam int CORR_W     = TARGET_W;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths of the scaling path.
  localparam int PROD_W    = GAIN_W + 1 + COORD_W;
  localparam int SCALE_W   = PROD_W + 1;
  localparam int FRAC_W    = 24;
  localparam int FLOOR_W   = SCALE_W - FRAC_W;
  localparam int OFF_SHIFT = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YOFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XLASH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YLASH = 3'd4;

  // Reset value of the gain register, 1/256 with 24 fractional bits.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;

  // Saturation limits of a point in steps.
  localparam logic signed [POINT_W-1:0] POINT_MAX = 24'sh7FFFFF;
  localparam logic signed [POINT_W-1:0] POINT_MIN = 24'sh800000;

  // Direction codes of an axis.
  localparam logic signed [DIR_W-1:0] DIR_ZERO = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;

  // Result of one axis update.
  typedef struct packed {
    logic signed [DIR_W-1:0]    dir;
    logic signed [CORR_W-1:0]   corr;
    logic signed [TARGET_W-1:0] target;
  } axis_t;

endpackage

// File: hdl/plot_point_queue_backlash.sv
// Top level: two-axis plotter point queue with scaling and backlash correction.
//
// Usage: software writes gain, offsets and backlash through cfg_write,
// cfg_index and cfg_data while the block is idle; writes take effect at once.
// A transaction is taken at a clock edge where start is high and busy is low.
// operation selects push (scale, floor and enqueue a point), pop (drop the
// newest queued point), tick (sample stepper_running and, when the motors
// are idle, issue the oldest point as a move target) or no operation.
// Every transaction gives exactly one result: done rises at the edge after
// the accepting edge and stays high for one cycle, together with
// move_issued, target_x, target_y, busy_res and push_dropped. The receiver
// cannot stall. No new transaction is taken while one is in work: the
// scaling multipliers and the queue memory read run in the accept cycle,
// and the memory write-back, offset add, floor and backlash update run
// in the work cycle, while busy is high.
// Reset clears the queue pointers, the motion state and the registers to
// their defaults; queue contents are left as they are and are never
// used before being written.
module plot_point_queue_backlash
  import ppqb_pkg::*;
#(
  parameter int QUEUE_DEPTH = PPQB_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            operation,
  input  logic signed [COORD_W-1:0]  x_coord,
  input  logic signed [COORD_W-1:0]  y_coord,
  input  logic                       stepper_running,
  output logic                       done,
  output logic                       move_issued,
  output logic signed [TARGET_W-1:0] target_x,
  output logic signed [TARGET_W-1:0] target_y,
  output logic                       busy_res,
  output logic                       push_dropped
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int QW    = 2 * POINT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  // Configuration registers.
  logic [GAIN_W-1:0]            gain;
  logic signed [OFFSET_W-1:0]   xoff;
  logic signed [OFFSET_W-1:0]   yoff;
  logic [BACKLASH_W-1:0]        x_lash;
  logic [BACKLASH_W-1:0]        y_lash;

  // Control and motion state.
  logic                         state;
  logic [IDX_W-1:0]             queue_head, queue_head_next;
  logic [CNT_W-1:0]             queue_count, queue_count_next;
  logic                         idle_flag, idle_flag_next;
  logic signed [POINT_W-1:0]    last_point_x, last_point_y;
  logic signed [DIR_W-1:0]      last_dir_x, last_dir_y;
  logic signed [CORR_W-1:0]     correction_x, correction_y;
  logic signed [POINT_W-1:0]    last_pushed_x, last_pushed_y;
  logic signed [POINT_W-1:0]    last_pushed_x_next, last_pushed_y_next;

  // Transaction held across the work cycle.
  logic [OP_W-1:0]              op_q;
  logic                         running_q;
  logic signed [PROD_W-1:0]     prod_x, prod_y;
  logic signed [PROD_W-1:0]     prod_x_next, prod_y_next;

  // Queue memory.
  logic [QW-1:0]                queue_mem [QUEUE_DEPTH];
  logic [QW-1:0]                rd_data;
  logic                         mem_we;
  logic [IDX_W-1:0]             wr_slot;
  logic [SUM_W-1:0]             slot_sum, slot_wrap;

  // Datapath of the work cycle.
  logic signed [SCALE_W-1:0]    sum_x, sum_y;
  logic signed [POINT_W-1:0]    px, py;
  logic signed [POINT_W-1:0]    qx, qy;
  axis_t                        ax_x, ax_y;
  logic                         issue;
  logic                         dropped;
  logic                         accept;

  // Floor result saturated to the point range.
  function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [FLOOR_W-1:0] v);
    logic signed [POINT_W-1:0] r;
    if (v > FLOOR_W'(POINT_MAX)) begin
      r = POINT_MAX;
    end else if (v < FLOOR_W'(POINT_MIN)) begin
      r = POINT_MIN;
    end else begin
      r = v[POINT_W-1:0];
    end
    return r;
  endfunction

  // One axis: direction of the move, backlash on reversal, corrected target.
  function automatic axis_t axis_step(
    input logic signed [POINT_W-1:0]  p,
    input logic signed [POINT_W-1:0]  last_p,
    input logic signed [DIR_W-1:0]    last_dir,
    input logic signed [CORR_W-1:0]   corr,
    input logic [BACKLASH_W-1:0]      backlash
  );
    axis_t                    r;
    logic signed [DIR_W-1:0]  dir;
    logic signed [CORR_W-1:0] corr_n;
    logic signed [CORR_W-1:0] lash;
    lash = CORR_W'($signed({1'b0, backlash}));
    if (p > last_p) begin
      dir = DIR_POS;
    end else if (p < last_p) begin
      dir = DIR_NEG;
    end else begin
      dir = DIR_ZERO;
    end
    corr_n = corr;
    if (dir != last_dir) begin
      if (dir == DIR_POS) begin
        corr_n = corr + lash;
      end else if (dir == DIR_NEG) begin
        corr_n = corr - lash;
      end
    end
    r.dir    = (dir == DIR_ZERO) ? last_dir : dir;
    r.corr   = corr_n;
    r.target = TARGET_W'(p) + TARGET_W'(corr_n);
    return r;
  endfunction

  assign busy   = (state == ST_WORK);
  assign accept = start && !busy;

  // Scaling products, formed from the ports in the accept cycle.
  always_comb begin
    prod_x_next = $signed({1'b0, gain}) * x_coord;
    prod_y_next = $signed({1'b0, gain}) * y_coord;
  end

  // Offset add at the product scale, then floor to whole steps.
  assign sum_x = SCALE_W'(prod_x) + SCALE_W'($signed({xoff, {OFF_SHIFT{1'b0}}}));
  assign sum_y = SCALE_W'(prod_y) + SCALE_W'($signed({yoff, {OFF_SHIFT{1'b0}}}));
  assign px    = sat_point(sum_x[SCALE_W-1:FRAC_W]);
  assign py    = sat_point(sum_y[SCALE_W-1:FRAC_W]);

  // Tail slot of the ring: head plus count, wrapped once.
  assign slot_sum  = SUM_W'(queue_head) + SUM_W'(queue_count);
  assign slot_wrap = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? slot_sum - SUM_W'(QUEUE_DEPTH)
                                                       : slot_sum;
  assign wr_slot   = slot_wrap[IDX_W-1:0];

  // Oldest point as read from the memory in the accept cycle.
  assign qx   = rd_data[QW-1:POINT_W];
  assign qy   = rd_data[POINT_W-1:0];
  assign ax_x = axis_step(qx, last_point_x, last_dir_x, correction_x, x_lash);
  assign ax_y = axis_step(qy, last_point_y, last_dir_y, correction_y, y_lash);

  // Queue and flag updates of the work cycle.
  always_comb begin
    queue_head_next    = queue_head;
    queue_count_next   = queue_count;
    idle_flag_next     = idle_flag;
    last_pushed_x_next = last_pushed_x;
    last_pushed_y_next = last_pushed_y;
    mem_we             = 1'b0;
    issue              = 1'b0;
    dropped            = 1'b0;
    unique case (op_q)
      OP_PUSH: begin
        if (px != last_pushed_x || py != last_pushed_y) begin
          if (queue_count == CNT_W'(QUEUE_DEPTH)) begin
            dropped = 1'b1;
          end else begin
            mem_we             = 1'b1;
            queue_count_next   = queue_count + 1'b1;
            last_pushed_x_next = px;
            last_pushed_y_next = py;
          end
        end
      end
      OP_POP: begin
        if (queue_count != '0) begin
          queue_count_next = queue_count - 1'b1;
        end
      end
      OP_TICK: begin
        idle_flag_next = idle_flag || !running_q;
        if (idle_flag_next && queue_count != '0) begin
          issue            = 1'b1;
          idle_flag_next   = 1'b0;
          queue_count_next = queue_count - 1'b1;
          queue_head_next  = (queue_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : queue_head + 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Queue memory. Each transaction finishes its write before the next one
  // can be accepted, so a read never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we && state == ST_WORK) begin
      queue_mem[wr_slot] <= {px, py};
    end
    if (accept) begin
      rd_data <= queue_mem[queue_head];
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= operation;
      running_q <= stepper_running;
      prod_x    <= prod_x_next;
      prod_y    <= prod_y_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      xoff   <= '0;
      yoff   <= '0;
      x_lash <= '0;
      y_lash <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:  gain   <= cfg_data[GAIN_W-1:0];
        REG_XOFF:  xoff   <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_YOFF:  yoff   <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_XLASH: x_lash <= cfg_data[BACKLASH_W-1:0];
        REG_YLASH: y_lash <= cfg_data[BACKLASH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, state update and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      move_issued   <= 1'b0;
      target_x      <= '0;
      target_y      <= '0;
      busy_res      <= 1'b0;
      push_dropped  <= 1'b0;
      queue_head    <= '0;
      queue_count   <= '0;
      idle_flag     <= 1'b1;
      last_point_x  <= '0;
      last_point_y  <= '0;
      last_dir_x    <= DIR_ZERO;
      last_dir_y    <= DIR_ZERO;
      correction_x  <= '0;
      correction_y  <= '0;
      last_pushed_x <= '0;
      last_pushed_y <= '0;
    end else begin
      done <= 1'b0;
      if (state == ST_IDLE) begin
        if (accept) begin
          state <= ST_WORK;
        end
      end else begin
        state         <= ST_IDLE;
        done          <= 1'b1;
        move_issued   <= issue;
        target_x      <= issue ? ax_x.target : '0;
        target_y      <= issue ? ax_y.target : '0;
        busy_res      <= !idle_flag_next;
        push_dropped  <= dropped;
        queue_head    <= queue_head_next;
        queue_count   <= queue_count_next;
        idle_flag     <= idle_flag_next;
        last_pushed_x <= last_pushed_x_next;
        last_pushed_y <= last_pushed_y_next;
        if (issue) begin
          last_point_x <= qx;
          last_point_y <= qy;
          last_dir_x   <= ax_x.dir;
          last_dir_y   <= ax_y.dir;
          correction_x <= ax_x.corr;
          correction_y <= ax_y.corr;
        end
      end
    end
  end

endmodule

// File: hdl/ppqb_checker.sv
// Port-level checker for the plotter point queue, bound to the top level.
module ppqb_checker
  import ppqb_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       move_issued,
  input logic signed [TARGET_W-1:0] target_x,
  input logic signed [TARGET_W-1:0] target_y,
  input logic                       busy_res,
  input logic                       push_dropped
);

  // An accepted transaction first holds busy with done low, then raises done with busy low.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done) ##1 (done && !busy))
    else $error("accepted transaction did not give exactly one timed result");

  // An issued move leaves the motors marked as running.
  a_move_busy: assert property (@(posedge clk) disable iff (rst)
    (done && move_issued) |-> busy_res)
    else $error("move issued while the block reports idle");

  // Targets read zero when no move is issued.
  a_idle_target: assert property (@(posedge clk) disable iff (rst)
    (done && !move_issued) |-> (target_x == '0 && target_y == '0))
    else $error("nonzero target without an issued move");

  // A refused push never issues a move in the same transaction.
  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    (done && push_dropped) |-> !move_issued)
    else $error("dropped push and issued move in one transaction");

endmodule

bind plot_point_queue_backlash ppqb_checker u_ppqb_checker (.*);
